[rtl/mte_pkg.sv]
// Shared types, constants and helpers for the matrix transform engine.
// No dependencies.
package mte_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int DIM       = 4;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int SUM_W     = PROD_W + 2;

    localparam logic signed [DATA_W-1:0] FX_ONE = DATA_W'(64'd1 << FRAC_BITS);
    localparam logic signed [SUM_W-1:0]  SAT_MAX = SUM_W'(64'sh7FFF_FFFF);
    localparam logic signed [SUM_W-1:0]  SAT_MIN = -SAT_MAX - SUM_W'(1);

    typedef enum logic [2:0] {
        KIND_WRITE  = 3'd0,
        KIND_DIAG   = 3'd1,
        KIND_STAGE  = 3'd2,
        KIND_XF_VEC = 3'd3,
        KIND_XF_PNT = 3'd4
    } t_kind;

    localparam logic [3:0] LAST_INDEX = 4'd15;

    // Controller to datapath commands, one set per cycle.
    typedef struct packed {
        logic       wr_elem;
        logic       set_diag;
        logic       wr_stage;
        logic       load_vec;
        logic       vec_point;
        logic       mat_rd;
        logic [1:0] mat_addr;
        logic       stg_rd;
        logic [1:0] stg_addr;
        logic       mul_go;
        logic       mul_stage;
        logic [1:0] mul_tag;
        logic       mul_zero;
        logic       commit;
        logic [1:0] commit_row;
    } t_cmd;

    // Floor shift by the fraction bits, then clamp to signed 32 bits.
    function automatic logic signed [DATA_W-1:0] sat_shift(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] q;
        q = s >>> FRAC_BITS;
        if (q > SAT_MAX) begin
            return SAT_MAX[DATA_W-1:0];
        end else if (q < SAT_MIN) begin
            return SAT_MIN[DATA_W-1:0];
        end
        return q[DATA_W-1:0];
    endfunction

endpackage

[rtl/matrix_transform_engine.sv]
// Transform: result strobe once the last component is registered; busy until then, so one at a time.
// Matrix product (staging element 15): busy until every row of the result is written back.
// Element write, diagonal load and other staging: done at the accepting edge, never busy.
// Reset (i_rst_n low, synchronous) empties both stores to zero and idles the sequencer.
// Results are held for one cycle under o_valid; the receiver cannot stall.
// Top level; instantiates mte_ctrl and mte_datapath, uses mte_pkg.
module matrix_transform_engine (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [2:0]                        i_kind,
    input  logic [3:0]                        i_index,
    input  logic signed [mte_pkg::DATA_W-1:0] i_value,
    input  logic signed [mte_pkg::DATA_W-1:0] i_vec_x,
    input  logic signed [mte_pkg::DATA_W-1:0] i_vec_y,
    input  logic signed [mte_pkg::DATA_W-1:0] i_vec_z,
    input  logic signed [mte_pkg::DATA_W-1:0] i_vec_w,
    output logic                              o_valid,
    output logic signed [mte_pkg::DATA_W-1:0] o_out_x,
    output logic signed [mte_pkg::DATA_W-1:0] o_out_y,
    output logic signed [mte_pkg::DATA_W-1:0] o_out_z,
    output logic signed [mte_pkg::DATA_W-1:0] o_out_w
);

    // Sequencer drives the datapath with a command word each cycle.
    // Transform: four row reads, each feeding the four multipliers in the
    // next cycle; the products are summed, shifted and clamped two stages
    // on, in r_sum and then r_res, one result component per row read.
    // Product: per result row, one matrix row read is held while the four
    // staged columns stream past; the row is written back when complete,
    // which is safe because later rows never read it.
    mte_pkg::t_cmd cmd;

    mte_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_kind  (i_kind),
        .i_index (i_index),
        .o_cmd   (cmd),
        .o_valid (o_valid)
    );

    mte_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_index (i_index),
        .i_value (i_value),
        .i_vec_x (i_vec_x),
        .i_vec_y (i_vec_y),
        .i_vec_z (i_vec_z),
        .i_vec_w (i_vec_w),
        .o_out_x (o_out_x),
        .o_out_y (o_out_y),
        .o_out_z (o_out_z),
        .o_out_w (o_out_w)
    );

endmodule

[rtl/mte_ctrl.sv]
// Sequencer for the matrix transform engine: accepts items and steps
// the datapath through transforms and matrix products. Uses mte_pkg.
module mte_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          i_kind,
    input  logic [3:0]          i_index,
    output mte_pkg::t_cmd       o_cmd,
    output logic                o_valid
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_XF   = 3'b010,
        S_MM   = 3'b100
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_k, n_k;
    logic [1:0] r_row, n_row;
    logic       r_point, n_point;
    logic       r_strobe, n_strobe;
    logic       accept;
    logic [1:0] k_m1;

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_strobe;
    assign accept  = start && (r_state == S_IDLE);
    assign k_m1    = r_k[1:0] - 2'd1;

    always_comb begin
        o_cmd    = '0;
        n_state  = r_state;
        n_k      = r_k;
        n_row    = r_row;
        n_point  = r_point;
        n_strobe = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_k   = 3'd0;
                    n_row = 2'd0;
                    unique case (i_kind)
                        mte_pkg::KIND_WRITE: o_cmd.wr_elem = 1'b1;
                        mte_pkg::KIND_DIAG:  o_cmd.set_diag = 1'b1;
                        mte_pkg::KIND_STAGE: begin
                            o_cmd.wr_stage = 1'b1;
                            if (i_index == mte_pkg::LAST_INDEX) begin
                                n_state = S_MM;
                            end
                        end
                        mte_pkg::KIND_XF_VEC, mte_pkg::KIND_XF_PNT: begin
                            o_cmd.load_vec  = 1'b1;
                            o_cmd.vec_point = (i_kind == mte_pkg::KIND_XF_PNT);
                            n_point         = (i_kind == mte_pkg::KIND_XF_PNT);
                            n_state         = S_XF;
                        end
                        default: ;
                    endcase
                end
            end
            S_XF: begin
                // rows read at k 0..3, multiplied in the next cycle
                o_cmd.mat_rd   = (r_k < 3'd4);
                o_cmd.mat_addr = r_k[1:0];
                o_cmd.mul_go   = (r_k >= 3'd1) && (r_k <= 3'd4);
                o_cmd.mul_tag  = k_m1;
                o_cmd.mul_zero = r_point && (k_m1 == 2'd3);
                if (r_k == 3'd6) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            S_MM: begin
                // one matrix row against the four staged columns
                o_cmd.mat_rd     = (r_k == 3'd0);
                o_cmd.mat_addr   = r_row;
                o_cmd.stg_rd     = (r_k < 3'd4);
                o_cmd.stg_addr   = r_k[1:0];
                o_cmd.mul_go     = (r_k >= 3'd1) && (r_k <= 3'd4);
                o_cmd.mul_stage  = 1'b1;
                o_cmd.mul_tag    = k_m1;
                o_cmd.commit     = (r_k == 3'd7);
                o_cmd.commit_row = r_row;
                n_k              = r_k + 3'd1;
                if (r_k == 3'd7) begin
                    if (r_row == 2'd3) begin
                        n_state = S_IDLE;
                    end else begin
                        n_row = r_row + 2'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_k      <= 3'd0;
            r_row    <= 2'd0;
            r_point  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_row    <= n_row;
            r_point  <= n_point;
            r_strobe <= n_strobe;
        end
    end

endmodule

[rtl/mte_datapath.sv]
// Matrix and staging stores, four multipliers, adder and saturation stage.
// Uses mte_pkg; driven by mte_ctrl commands.
module mte_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mte_pkg::t_cmd                 i_cmd,
    input  logic [3:0]                    i_index,
    input  logic signed [mte_pkg::DATA_W-1:0] i_value,
    input  logic signed [mte_pkg::DATA_W-1:0] i_vec_x,
    input  logic signed [mte_pkg::DATA_W-1:0] i_vec_y,
    input  logic signed [mte_pkg::DATA_W-1:0] i_vec_z,
    input  logic signed [mte_pkg::DATA_W-1:0] i_vec_w,
    output logic signed [mte_pkg::DATA_W-1:0] o_out_x,
    output logic signed [mte_pkg::DATA_W-1:0] o_out_y,
    output logic signed [mte_pkg::DATA_W-1:0] o_out_z,
    output logic signed [mte_pkg::DATA_W-1:0] o_out_w
);

    // matrix: one memory per column, addressed by row
    // staging: one memory per row, addressed by column
    logic signed [mte_pkg::DATA_W-1:0] mat_mem [mte_pkg::DIM][mte_pkg::DIM];
    logic signed [mte_pkg::DATA_W-1:0] stg_mem [mte_pkg::DIM][mte_pkg::DIM];
    logic                              r_mat_vld [mte_pkg::DIM][mte_pkg::DIM];
    logic                              r_stg_vld [mte_pkg::DIM][mte_pkg::DIM];

    logic signed [mte_pkg::DATA_W-1:0] r_mrow [mte_pkg::DIM];
    logic signed [mte_pkg::DATA_W-1:0] r_scol [mte_pkg::DIM];
    logic signed [mte_pkg::DATA_W-1:0] r_vec  [mte_pkg::DIM];
    logic signed [mte_pkg::DATA_W-1:0] r_res  [mte_pkg::DIM];

    logic signed [mte_pkg::PROD_W-1:0] r_prod [mte_pkg::DIM];
    logic signed [mte_pkg::SUM_W-1:0]  r_sum;
    logic                              r_pv, r_sv;
    logic [1:0]                        r_ptag, r_stag;
    logic                              r_pzero, r_szero;

    logic signed [mte_pkg::DATA_W-1:0] opb [mte_pkg::DIM];
    logic signed [mte_pkg::SUM_W-1:0]  sum_all;

    always_comb begin
        sum_all = '0;
        for (int e = 0; e < mte_pkg::DIM; e++) begin
            opb[e]  = i_cmd.mul_stage ? r_scol[e] : r_vec[e];
            sum_all = sum_all + mte_pkg::SUM_W'(r_prod[e]);
        end
    end

    // valid bits: an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < mte_pkg::DIM; c++) begin
                for (int r = 0; r < mte_pkg::DIM; r++) begin
                    r_mat_vld[c][r] <= 1'b0;
                    r_stg_vld[c][r] <= 1'b0;
                end
            end
        end else begin
            if (i_cmd.wr_elem) begin
                r_mat_vld[i_index[3:2]][i_index[1:0]] <= 1'b1;
            end
            if (i_cmd.set_diag) begin
                for (int c = 0; c < mte_pkg::DIM; c++) begin
                    for (int r = 0; r < mte_pkg::DIM; r++) begin
                        r_mat_vld[c][r] <= (c == r);
                    end
                end
            end
            if (i_cmd.commit) begin
                for (int c = 0; c < mte_pkg::DIM; c++) begin
                    r_mat_vld[c][i_cmd.commit_row] <= 1'b1;
                end
            end
            if (i_cmd.wr_stage) begin
                r_stg_vld[i_index[1:0]][i_index[3:2]] <= 1'b1;
            end
        end
    end

    // store writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_elem) begin
            mat_mem[i_index[3:2]][i_index[1:0]] <= i_value;
        end
        if (i_cmd.set_diag) begin
            for (int c = 0; c < mte_pkg::DIM; c++) begin
                mat_mem[c][c] <= i_value;
            end
        end
        if (i_cmd.commit) begin
            for (int c = 0; c < mte_pkg::DIM; c++) begin
                mat_mem[c][i_cmd.commit_row] <= r_res[c];
            end
        end
        if (i_cmd.wr_stage) begin
            stg_mem[i_index[1:0]][i_index[3:2]] <= i_value;
        end
    end

    // registered reads and vector capture
    always_ff @(posedge i_clk) begin
        for (int e = 0; e < mte_pkg::DIM; e++) begin
            if (i_cmd.mat_rd) begin
                r_mrow[e] <= r_mat_vld[e][i_cmd.mat_addr] ? mat_mem[e][i_cmd.mat_addr] : '0;
            end
            if (i_cmd.stg_rd) begin
                r_scol[e] <= r_stg_vld[e][i_cmd.stg_addr] ? stg_mem[e][i_cmd.stg_addr] : '0;
            end
        end
        if (i_cmd.load_vec) begin
            r_vec[0] <= i_vec_x;
            r_vec[1] <= i_vec_y;
            r_vec[2] <= i_vec_z;
            r_vec[3] <= i_cmd.vec_point ? mte_pkg::FX_ONE : i_vec_w;
        end
    end

    // multiply, sum, shift and clamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            r_pv <= i_cmd.mul_go;
            r_sv <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_go) begin
            for (int e = 0; e < mte_pkg::DIM; e++) begin
                r_prod[e] <= r_mrow[e] * opb[e];
            end
            r_ptag  <= i_cmd.mul_tag;
            r_pzero <= i_cmd.mul_zero;
        end
        if (r_pv) begin
            r_sum   <= sum_all;
            r_stag  <= r_ptag;
            r_szero <= r_pzero;
        end
        if (r_sv) begin
            r_res[r_stag] <= r_szero ? '0 : mte_pkg::sat_shift(r_sum);
        end
    end

    assign o_out_x = r_res[0];
    assign o_out_y = r_res[1];
    assign o_out_z = r_res[2];
    assign o_out_w = r_res[3];

endmodule

[rtl/mte_checker.sv]
// Port-level timing checks for matrix_transform_engine, bound to the top level.
// Uses mte_pkg kind codes.
module mte_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic [2:0]                        i_kind,
    input logic [3:0]                        i_index,
    input logic                              o_valid,
    input logic signed [mte_pkg::DATA_W-1:0] o_out_w
);

    logic acc_xf;
    logic acc_pnt;
    assign acc_xf  = start && !busy &&
                     (i_kind == mte_pkg::KIND_XF_VEC || i_kind == mte_pkg::KIND_XF_PNT);
    assign acc_pnt = start && !busy && (i_kind == mte_pkg::KIND_XF_PNT);

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_xf_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_xf |-> ##8 o_valid)
        else $error("transform result missing");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(acc_xf, 8))
        else $error("result without a transform");

    a_point_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_pnt |-> ##8 (o_out_w == '0))
        else $error("point transform w not zero");

    a_mm_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == mte_pkg::KIND_STAGE && i_index == mte_pkg::LAST_INDEX)
        |=> busy)
        else $error("matrix product did not start");

endmodule

bind matrix_transform_engine mte_checker u_mte_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_kind  (i_kind),
    .i_index (i_index),
    .o_valid (o_valid),
    .o_out_w (o_out_w)
);

[test/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for matrix_transform_engine: a directed table, then random traffic.
// Carries its own fixed-point matrix predictor; depends on mte_pkg and the engine RTL.
module tb;

    typedef logic signed [mte_pkg::DATA_W-1:0] t_q;

    // Opcodes the engine must ignore: no state change, no result.
    localparam logic [2:0] KIND_SPARE_LO  = 3'd5;
    localparam logic [2:0] KIND_SPARE_MID = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI  = 3'd7;

    localparam int RAND_ITEMS   = 1425;
    localparam int DRAIN_CYCLES = 48;        // longer than a full matrix product
    localparam int RUN_LIMIT_NS = 5_000_000;

    typedef struct {
        logic [2:0] kind;
        logic [3:0] idx;
        t_q         value;
        t_q         vx, vy, vz, vw;
    } t_item;

    typedef struct {
        t_q x, y, z, w;
    } t_vec4;

    // One row of the directed table: an item and, where it is obvious, its answer.
    typedef struct {
        t_item it;
        bit    fixed;
        t_vec4 ans;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [2:0] i_kind = '0;
    logic [3:0] i_index = '0;
    t_q i_value = '0;
    t_q i_vec_x = '0;
    t_q i_vec_y = '0;
    t_q i_vec_z = '0;
    t_q i_vec_w = '0;
    logic o_valid;
    t_q o_out_x, o_out_y, o_out_z, o_out_w;

    matrix_transform_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_kind  (i_kind),
        .i_index (i_index),
        .i_value (i_value),
        .i_vec_x (i_vec_x),
        .i_vec_y (i_vec_y),
        .i_vec_z (i_vec_z),
        .i_vec_w (i_vec_w),
        .o_valid (o_valid),
        .o_out_x (o_out_x),
        .o_out_y (o_out_y),
        .o_out_z (o_out_z),
        .o_out_w (o_out_w)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: the left matrix (column major, row + 4*col) and the staged right matrix.
    t_q mat_q[16];
    t_q stage_q[16];

    t_vec4 vertex_due[$];    // transform results still to come, oldest first
    t_row  plan[$];

    int n_errors   = 0;
    int n_sent     = 0;
    int n_checked  = 0;
    int n_products = 0;
    int calm_left  = 0;      // transfers still to go in a stretch with no idling

    // Row r of the matrix dotted with b: exact sum, floor shift, clamp to 32 bits.
    function automatic t_q row_dot(input int r, input t_q b0, input t_q b1,
                                   input t_q b2, input t_q b3);
        logic signed [mte_pkg::SUM_W-1:0] acc;
        logic signed [mte_pkg::SUM_W-1:0] pa;
        logic signed [mte_pkg::SUM_W-1:0] pb;
        t_q b[4];
        b[0] = b0;
        b[1] = b1;
        b[2] = b2;
        b[3] = b3;
        acc = '0;
        for (int e = 0; e < mte_pkg::DIM; e++) begin
            pa = mte_pkg::SUM_W'(mat_q[r + 4 * e]);
            pb = mte_pkg::SUM_W'(b[e]);
            acc = acc + pa * pb;
        end
        acc = acc >>> mte_pkg::FRAC_BITS;
        if (acc > 66'sh7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (acc < -66'sh8000_0000) begin
            return 32'sh8000_0000;
        end
        return acc[mte_pkg::DATA_W-1:0];
    endfunction

    // Applies one accepted transfer to the predictor; hands back a vertex for transforms.
    task automatic advance_matrix(input t_item it, output bit has_res, output t_vec4 res);
        t_q nxt[16];
        t_q w_in;
        has_res = 1'b0;
        res = '{x: '0, y: '0, z: '0, w: '0};
        case (it.kind)
            mte_pkg::KIND_WRITE: begin
                mat_q[it.idx] = it.value;
            end
            mte_pkg::KIND_DIAG: begin
                for (int i = 0; i < 16; i++) begin
                    mat_q[i] = (i % 5 == 0) ? it.value : '0;
                end
            end
            mte_pkg::KIND_STAGE: begin
                stage_q[it.idx] = it.value;
                // staging the last element multiplies; the stage keeps its contents
                if (it.idx == mte_pkg::LAST_INDEX) begin
                    for (int c = 0; c < mte_pkg::DIM; c++) begin
                        for (int r = 0; r < mte_pkg::DIM; r++) begin
                            nxt[r + 4 * c] = row_dot(r, stage_q[4 * c], stage_q[4 * c + 1],
                                                     stage_q[4 * c + 2], stage_q[4 * c + 3]);
                        end
                    end
                    for (int i = 0; i < 16; i++) begin
                        mat_q[i] = nxt[i];
                    end
                    n_products++;
                end
            end
            mte_pkg::KIND_XF_VEC, mte_pkg::KIND_XF_PNT: begin
                // a point has w = 1.0 going in and w = 0 coming out
                w_in = (it.kind == mte_pkg::KIND_XF_PNT) ? mte_pkg::FX_ONE : it.vw;
                has_res = 1'b1;
                res.x = row_dot(0, it.vx, it.vy, it.vz, w_in);
                res.y = row_dot(1, it.vx, it.vy, it.vz, w_in);
                res.z = row_dot(2, it.vx, it.vy, it.vz, w_in);
                res.w = (it.kind == mte_pkg::KIND_XF_PNT) ? '0 :
                        row_dot(3, it.vx, it.vy, it.vz, w_in);
            end
            default: begin
            end
        endcase
    endtask

    // Idle length after a transfer: mostly none, sometimes a few, now and then a long one.
    function automatic int gap_len();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end else if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Random Q16.16 value: mostly small so products stay in range, some full-width and extremes.
    function automatic t_q rand_q();
        t_q v;
        case ($urandom_range(0, 9))
            0: v = $urandom;
            1: begin
                case ($urandom_range(0, 4))
                    0: v = 32'sh7FFF_FFFF;
                    1: v = 32'sh8000_0000;
                    2: v = mte_pkg::FX_ONE;
                    3: v = -mte_pkg::FX_ONE;
                    default: v = '0;
                endcase
            end
            2: v = t_q'($urandom_range(0, 65535)) - 32'sd32768;
            default: v = t_q'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
        endcase
        return v;
    endfunction

    // Present one item at the falling edge, hold it until taken, predict, then maybe idle.
    task automatic send(input t_item it, input bit fixed, input t_vec4 ans);
        bit    has_res;
        t_vec4 res;
        int    gap;
        @(negedge i_clk);
        i_kind  <= it.kind;
        i_index <= it.idx;
        i_value <= it.value;
        i_vec_x <= it.vx;
        i_vec_y <= it.vy;
        i_vec_z <= it.vz;
        i_vec_w <= it.vw;
        start   <= 1'b1;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        advance_matrix(it, has_res, res);
        if (has_res) begin
            if (fixed) begin
                vertex_due.push_back(ans);
            end else begin
                vertex_due.push_back(res);
            end
        end
        n_sent++;
        gap = gap_len();
        if (gap > 0) begin
            // start drops; the payload turns to junk, which the engine must not look at
            @(negedge i_clk);
            start   <= 1'b0;
            i_kind  <= 3'($urandom);
            i_index <= 4'($urandom);
            i_value <= $urandom;
            i_vec_x <= $urandom;
            i_vec_y <= $urandom;
            i_vec_z <= $urandom;
            i_vec_w <= $urandom;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    function automatic t_item mk(input logic [2:0] kind, input logic [3:0] idx, input t_q value,
                                 input t_q vx, input t_q vy, input t_q vz, input t_q vw);
        t_item it;
        it.kind  = kind;
        it.idx   = idx;
        it.value = value;
        it.vx    = vx;
        it.vy    = vy;
        it.vz    = vz;
        it.vw    = vw;
        return it;
    endfunction

    // Table row for a matrix update or an ignored opcode.
    function automatic void op(input logic [2:0] kind, input logic [3:0] idx, input t_q value);
        t_row rw;
        rw.it    = mk(kind, idx, value, $urandom, $urandom, $urandom, $urandom);
        rw.fixed = 1'b0;
        rw.ans   = '{x: '0, y: '0, z: '0, w: '0};
        plan.push_back(rw);
    endfunction

    // Table row for a transform; fixed set means the answer is the one typed in.
    function automatic void xf(input logic [2:0] kind, input t_q vx, input t_q vy, input t_q vz,
                               input t_q vw, input bit fixed, input t_q ex, input t_q ey,
                               input t_q ez, input t_q ew);
        t_row rw;
        rw.it    = mk(kind, 4'($urandom), $urandom, vx, vy, vz, vw);
        rw.fixed = fixed;
        rw.ans   = '{x: ex, y: ey, z: ez, w: ew};
        plan.push_back(rw);
    endfunction

    task automatic check_field(input string name, input t_q want, input t_q got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            n_errors++;
        end
    endtask

    // Results cannot be held off, so each strobe is checked at the edge that ends it.
    always @(posedge i_clk) begin : result_check
        t_vec4 want;
        if (i_rst_n && o_valid) begin
            if (vertex_due.size() == 0) begin
                $error("result with none expected: %h %h %h %h",
                       o_out_x, o_out_y, o_out_z, o_out_w);
                n_errors++;
            end else begin
                want = vertex_due.pop_front();
                check_field("out_x", want.x, o_out_x);
                check_field("out_y", want.y, o_out_y);
                check_field("out_z", want.z, o_out_z);
                check_field("out_w", want.w, o_out_w);
                n_checked++;
            end
        end
    end

    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("tb failed");
        $finish;
    end

    initial begin : stimulus
        t_item it;
        t_vec4 none;
        int    live;
        int    pick;
        none = '{x: '0, y: '0, z: '0, w: '0};
        for (int i = 0; i < 16; i++) begin
            mat_q[i]   = '0;
            stage_q[i] = '0;
        end

        // Directed table.
        // Straight out of reset the matrix is all zero, whatever the vector.
        xf(mte_pkg::KIND_XF_VEC, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd1, -32'sd1,
           1'b1, '0, '0, '0, '0);
        xf(mte_pkg::KIND_XF_PNT, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd1, -32'sd1,
           1'b1, '0, '0, '0, '0);
        // Identity (index must be ignored): vectors pass through, a point loses its w.
        op(mte_pkg::KIND_DIAG, 4'd9, mte_pkg::FX_ONE);
        xf(mte_pkg::KIND_XF_VEC, 32'sh0001_8000, 32'shFFFE_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
           1'b1, 32'sh0001_8000, 32'shFFFE_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
        xf(mte_pkg::KIND_XF_PNT, 32'sh0003_0000, 32'shFFFF_0000, 32'sh1234_5678, 32'sh7FFF_FFFF,
           1'b1, 32'sh0003_0000, 32'shFFFF_0000, 32'sh1234_5678, '0);
        // Largest diagonals: both saturation limits.
        op(mte_pkg::KIND_DIAG, 4'd0, 32'sh7FFF_FFFF);
        xf(mte_pkg::KIND_XF_VEC, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
           1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
        op(mte_pkg::KIND_DIAG, 4'd15, 32'sh8000_0000);
        xf(mte_pkg::KIND_XF_VEC, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd1, -32'sd1,
           1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'shFFFF_8000, 32'sh0000_8000);
        // Smallest diagonal: the shift floors towards minus infinity.
        op(mte_pkg::KIND_DIAG, 4'd3, 32'sd1);
        xf(mte_pkg::KIND_XF_VEC, -32'sd1, 32'sd1, 32'sh0000_FFFF, 32'shFFFF_0000,
           1'b1, -32'sd1, '0, '0, -32'sd1);
        // Element writes on top of identity, translation column included.
        op(mte_pkg::KIND_DIAG, 4'd0, mte_pkg::FX_ONE);
        op(mte_pkg::KIND_WRITE, 4'd12, 32'sh0005_0000);
        op(mte_pkg::KIND_WRITE, 4'd13, 32'sh8000_0000);
        op(mte_pkg::KIND_WRITE, 4'd0, 32'sh7FFF_FFFF);
        xf(mte_pkg::KIND_XF_PNT, mte_pkg::FX_ONE, mte_pkg::FX_ONE, mte_pkg::FX_ONE, '0,
           1'b0, '0, '0, '0, '0);
        // Staging: the last element triggers the product; staging it alone multiplies again.
        op(mte_pkg::KIND_STAGE, 4'd0, 32'sh0002_0000);
        op(mte_pkg::KIND_STAGE, 4'd5, 32'sh8000_0000);
        op(mte_pkg::KIND_STAGE, mte_pkg::LAST_INDEX, 32'shFFFF_8000);
        xf(mte_pkg::KIND_XF_VEC, mte_pkg::FX_ONE, -mte_pkg::FX_ONE, 32'sh0000_4000,
           mte_pkg::FX_ONE, 1'b0, '0, '0, '0, '0);
        op(mte_pkg::KIND_STAGE, mte_pkg::LAST_INDEX, mte_pkg::FX_ONE);
        xf(mte_pkg::KIND_XF_VEC, 32'sh0001_0001, 32'sh0000_0003, -32'sh0002_0000,
           32'sh0000_8000, 1'b0, '0, '0, '0, '0);
        // Unused opcodes leave everything as it was.
        op(KIND_SPARE_LO, 4'd0, 32'sh7FFF_FFFF);
        op(KIND_SPARE_MID, 4'd5, 32'sh8000_0000);
        op(KIND_SPARE_HI, mte_pkg::LAST_INDEX, mte_pkg::FX_ONE);
        xf(mte_pkg::KIND_XF_PNT, 32'sh0002_0000, 32'sh0000_8000, -32'sh0001_0000,
           32'sh1234_5678, 1'b0, '0, '0, '0, '0);

        // Synchronous reset, held low from the start, released on a falling edge.
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            send(plan[k].it, plan[k].fixed, plan[k].ans);
        end

        // Random traffic. Ignored opcodes are extra and do not count towards the total.
        live = 0;
        while (live < RAND_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                // a whole right-hand matrix staged in order, ending in a product
                for (int i = 0; i < 16; i++) begin
                    send(mk(mte_pkg::KIND_STAGE, 4'(i), rand_q(), $urandom, $urandom,
                            $urandom, $urandom), 1'b0, none);
                end
                live += 16;
            end else if (pick < 9) begin
                it = mk(mte_pkg::KIND_DIAG, 4'($urandom), rand_q(), $urandom, $urandom,
                        $urandom, $urandom);
                if ($urandom_range(0, 1) == 0) begin
                    it.value = mte_pkg::FX_ONE;
                end
                send(it, 1'b0, none);
                live++;
            end else if (pick < 30) begin
                send(mk(mte_pkg::KIND_WRITE, 4'($urandom), rand_q(), $urandom, $urandom,
                        $urandom, $urandom), 1'b0, none);
                live++;
            end else if (pick < 38) begin
                send(mk(mte_pkg::KIND_STAGE, 4'($urandom), rand_q(), $urandom, $urandom,
                        $urandom, $urandom), 1'b0, none);
                live++;
            end else if (pick < 43) begin
                send(mk(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)), 4'($urandom),
                        $urandom, $urandom, $urandom, $urandom, $urandom), 1'b0, none);
            end else begin
                it = mk(($urandom_range(0, 1) == 0) ? mte_pkg::KIND_XF_VEC :
                        mte_pkg::KIND_XF_PNT, 4'($urandom),
                        $urandom, rand_q(), rand_q(), rand_q(), rand_q());
                send(it, 1'b0, none);
                live++;
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (vertex_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d transfers sent, %0d vertices checked, %0d matrix products predicted",
                 n_sent, n_checked, n_products);
        if (n_errors == 0 && vertex_due.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
